/* design/tip_pkg.sv */
package tip_pkg;

  // telnet command and option codes
  localparam logic [7:0] CMD_IAC  = 8'hff;
  localparam logic [7:0] CMD_SB   = 8'hfa;
  localparam logic [7:0] CMD_SE   = 8'hf0;
  localparam logic [7:0] CMD_WILL = 8'hfb;
  localparam logic [7:0] CMD_WONT = 8'hfc;
  localparam logic [7:0] CMD_DO   = 8'hfd;
  localparam logic [7:0] CMD_DONT = 8'hfe;
  localparam logic [7:0] OPT_ECHO = 8'h01;
  localparam logic [7:0] OPT_SGA  = 8'h03;

  // request action codes
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_CONNECT = 1'b1;

  // result kind codes
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] reply_verb;
    logic [7:0] reply_option;
  } result_t;

  // input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    rx_item_t item;
  } stage_t;

  // parser output handed to the result register
  typedef struct packed {
    logic    load;
    result_t result;
  } res_stage_t;

endpackage

/* design/tip_if.sv */
interface tip_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface tip_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [7:0] reply_verb;
  logic [7:0] reply_option;

  modport source (
    output valid, output result_kind, output data_byte,
    output reply_verb, output reply_option, input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte,
    input reply_verb, input reply_option, output ready
  );
endinterface

/* design/tip_in_reg.sv */
module tip_in_reg (
  input  logic           clk,
  input  logic           rst,
  tip_in_if.sink         rx,
  input  logic           advance,
  output tip_pkg::stage_t stage
);
  import tip_pkg::*;

  logic     valid;
  rx_item_t item;

  // take a new request whenever the register is empty or drains this cycle
  assign rx.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.action  <= rx.action;
      item.rx_byte <= rx.rx_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

/* design/tip_parser.sv */
module tip_parser (
  input  logic                clk,
  input  logic                rst,
  input  tip_pkg::stage_t     stage,
  input  logic                advance,
  output tip_pkg::res_stage_t res
);
  import tip_pkg::*;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_OPT    = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_command;
  logic [7:0] held_command_next;
  logic       has_result;
  result_t    result;
  logic [7:0] b;

  assign b = stage.item.rx_byte;

  // next parser state and the result of the byte in the input register
  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    has_result        = 1'b0;
    result            = '0;
    if (stage.item.action == ACT_CONNECT) begin
      phase_next        = PH_DATA;
      held_command_next = '0;
    end else begin
      case (phase)
        PH_IAC: begin
          if (b == CMD_IAC) begin
            phase_next         = PH_DATA;
            has_result         = 1'b1;
            result.result_kind = KIND_DATA;
            result.data_byte   = b;
          end else if (b == CMD_SB) begin
            phase_next = PH_SUB;
          end else if (b inside {CMD_WILL, CMD_WONT, CMD_DO, CMD_DONT}) begin
            held_command_next = b;
            phase_next        = PH_OPT;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_OPT: begin
          phase_next        = PH_DATA;
          held_command_next = '0;
          if (held_command == CMD_WILL) begin
            has_result          = 1'b1;
            result.result_kind  = KIND_REPLY;
            result.reply_option = b;
            result.reply_verb   = (b == OPT_ECHO || b == OPT_SGA) ? CMD_DO : CMD_DONT;
          end else if (held_command == CMD_DO) begin
            has_result          = 1'b1;
            result.result_kind  = KIND_REPLY;
            result.reply_option = b;
            result.reply_verb   = (b == OPT_SGA) ? CMD_WILL : CMD_WONT;
          end
        end
        PH_SUB: begin
          if (b == CMD_IAC) begin
            phase_next = PH_SUBIAC;
          end
        end
        PH_SUBIAC: begin
          phase_next = (b == CMD_SE) ? PH_DATA : PH_SUB;
        end
        default: begin
          // data phase, and unused codes behave the same
          if (b == CMD_IAC) begin
            phase_next = PH_IAC;
          end else begin
            phase_next         = PH_DATA;
            has_result         = 1'b1;
            result.result_kind = KIND_DATA;
            result.data_byte   = b;
          end
        end
      endcase
    end
  end

  // state moves only when the request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      held_command <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      held_command <= held_command_next;
    end
  end

  assign res.load   = advance && has_result;
  assign res.result = result;

endmodule

/* design/tip_out_reg.sv */
module tip_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  tip_pkg::res_stage_t res,
  output logic                space,
  tip_out_if.source           tx
);
  import tip_pkg::*;

  logic    valid;
  result_t data;

  // room for a new result when empty or being taken this cycle
  assign space = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.load) begin
      valid <= 1'b1;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      data <= res.result;
    end
  end

  assign tx.valid        = valid;
  assign tx.result_kind  = data.result_kind;
  assign tx.data_byte    = data.data_byte;
  assign tx.reply_verb   = data.reply_verb;
  assign tx.reply_option = data.reply_option;

endmodule

/* design/telnet_iac_stream_parser.sv */
// channel  dir  fields                                          handshake
// rx       in   action, rx_byte                                 valid / ready
// tx       out  result_kind, data_byte, reply_verb, reply_option valid / ready
//
// one request per cycle sustained while tx is ready; a taken request passes
// through the input register, the parse logic and the result register
// reset is synchronous on rst and returns the parser to the data phase
// a stalled tx holds its result; rx keeps accepting while the input register can
// drain, so a full pipe stalls rx only through the result register's ready
module telnet_iac_stream_parser (
  input  logic      clk,
  input  logic      rst,
  tip_in_if.sink    rx,
  tip_out_if.source tx
);
  import tip_pkg::*;

  stage_t     stage;
  res_stage_t res;
  logic       space;
  logic       advance;

  // the input register drains whenever the result register can take a result
  assign advance = stage.valid && space;

  tip_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .stage   (stage)
  );

  tip_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .res     (res)
  );

  tip_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .space (space),
    .tx    (tx)
  );

endmodule

/* design/tip_checker.sv */
module tip_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic       result_kind,
  input logic [7:0] data_byte,
  input logic [7:0] reply_verb,
  input logic [7:0] reply_option
);
  import tip_pkg::*;

  // a stalled result holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(result_kind) && $stable(data_byte)
      && $stable(reply_verb) && $stable(reply_option))
    else $error("tx result changed while stalled");

  // a reply carries one of the four negotiation verbs and no data
  a_reply_verb: assert property (@(posedge clk) disable iff (rst)
    tx_valid && result_kind == KIND_REPLY |-> data_byte == 8'h00
      && (reply_verb == CMD_WILL || reply_verb == CMD_WONT
       || reply_verb == CMD_DO || reply_verb == CMD_DONT))
    else $error("bad reply verb");

  // a data result leaves the reply fields clear
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    tx_valid && result_kind == KIND_DATA |-> reply_verb == 8'h00 && reply_option == 8'h00)
    else $error("data result with reply fields set");

  // DO replies only for the supported options
  a_agree_opt: assert property (@(posedge clk) disable iff (rst)
    tx_valid && result_kind == KIND_REPLY && reply_verb == CMD_DO
      |-> reply_option == OPT_ECHO || reply_option == OPT_SGA)
    else $error("DO sent for an unsupported option");

endmodule

bind telnet_iac_stream_parser tip_checker u_tip_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .result_kind  (tx.result_kind),
  .data_byte    (tx.data_byte),
  .reply_verb   (tx.reply_verb),
  .reply_option (tx.reply_option)
);

/* tb/sv/telnet_iac_stream_parser_tb.sv */
`timescale 1ns / 1ps

module telnet_iac_stream_parser_tb;
  import tip_pkg::*;

  localparam int RAND_ITEMS = 650;
  localparam int PRESS_AT   = 200;
  localparam int DRAIN_AT   = 420;
  localparam int LONG_HOLD  = 150;
  localparam int BURST_LEN  = 24;
  localparam int DRAIN_MAX  = 5000;

  localparam result_t NO_RESULT = '0;

  typedef enum logic [2:0] {
    PH_DATA       = 3'd0,
    PH_AFTER_IAC  = 3'd1,
    PH_OPTION     = 3'd2,
    PH_SUBNEG     = 3'd3,
    PH_SUBNEG_IAC = 3'd4
  } parse_phase_t;

  typedef struct packed {
    rx_item_t req;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  tip_in_if  rx ();
  tip_out_if tx ();

  telnet_iac_stream_parser dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx)
  );

  // parser model state
  parse_phase_t parse_st;
  logic [7:0]   held_verb;

  result_t   pending_results[$];
  stim_row_t dir_rows[$];
  rx_item_t  stim_q[$];

  int fail_count   = 0;
  int burst_left   = 0;
  bit long_hold_req = 1'b0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t mk_data(logic [7:0] b);
    result_t r;
    r = '0;
    r.result_kind = KIND_DATA;
    r.data_byte = b;
    return r;
  endfunction

  function automatic result_t mk_reply(logic [7:0] verb, logic [7:0] opt);
    result_t r;
    r = '0;
    r.result_kind = KIND_REPLY;
    r.reply_verb = verb;
    r.reply_option = opt;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic act, logic [7:0] b, bit typed, result_t want);
    stim_row_t s;
    s.req.action = act;
    s.req.rx_byte = b;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // advance the parser model by one byte, returns 1 when a result is produced
  function automatic bit parse_byte(input logic act, input logic [7:0] b,
                                    output result_t res);
    logic [7:0] verb;
    res = '0;
    if (act == ACT_CONNECT) begin
      parse_st = PH_DATA;
      held_verb = 8'h00;
      return 1'b0;
    end
    case (parse_st)
      PH_AFTER_IAC: begin
        if (b == CMD_IAC) begin
          parse_st = PH_DATA;
          res = mk_data(b);
          return 1'b1;
        end
        if (b == CMD_SB) begin
          parse_st = PH_SUBNEG;
        end else if (b == CMD_WILL || b == CMD_WONT || b == CMD_DO || b == CMD_DONT) begin
          held_verb = b;
          parse_st = PH_OPTION;
        end else begin
          parse_st = PH_DATA;
        end
        return 1'b0;
      end
      PH_OPTION: begin
        verb = held_verb;
        parse_st = PH_DATA;
        held_verb = 8'h00;
        if (verb == CMD_WILL) begin
          res = mk_reply((b == OPT_ECHO || b == OPT_SGA) ? CMD_DO : CMD_DONT, b);
          return 1'b1;
        end
        if (verb == CMD_DO) begin
          res = mk_reply((b == OPT_SGA) ? CMD_WILL : CMD_WONT, b);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_SUBNEG: begin
        if (b == CMD_IAC) parse_st = PH_SUBNEG_IAC;
        return 1'b0;
      end
      PH_SUBNEG_IAC: begin
        parse_st = (b == CMD_SE) ? PH_DATA : PH_SUBNEG;
        return 1'b0;
      end
      default: begin
        if (b == CMD_IAC) begin
          parse_st = PH_AFTER_IAC;
          return 1'b0;
        end
        parse_st = PH_DATA;
        res = mk_data(b);
        return 1'b1;
      end
    endcase
  endfunction

  // idle cycles before the next request: mostly short, a few long, some gapless runs
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 3) begin
      burst_left = $urandom_range(40, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void push_byte(logic act, logic [7:0] b);
    rx_item_t it;
    it.action = act;
    it.rx_byte = b;
    stim_q.push_back(it);
  endfunction

  // append one random telnet sequence, mostly well formed
  function automatic void add_sequence();
    int r;
    int n;
    int k;
    logic [7:0] verb;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 35) begin
      push_byte(ACT_BYTE, 8'($urandom_range(254)));
    end else if (r < 45) begin
      push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_BYTE, CMD_IAC);
    end else if (r < 75) begin
      case ($urandom_range(3))
        0: verb = CMD_WILL;
        1: verb = CMD_WONT;
        2: verb = CMD_DO;
        default: verb = CMD_DONT;
      endcase
      k = $urandom_range(99);
      if (k < 30) b = OPT_ECHO;
      else if (k < 60) b = OPT_SGA;
      else b = 8'($urandom_range(255));
      push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_BYTE, verb);
      push_byte(ACT_BYTE, b);
    end else if (r < 87) begin
      // subnegotiation with escapes and stray iac pairs
      push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_BYTE, CMD_SB);
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(99);
        if (k < 20) begin
          push_byte(ACT_BYTE, CMD_IAC);
          push_byte(ACT_BYTE, CMD_IAC);
        end else if (k < 30) begin
          b = 8'($urandom_range(255));
          if (b == CMD_SE) b = 8'h00;
          push_byte(ACT_BYTE, CMD_IAC);
          push_byte(ACT_BYTE, b);
        end else begin
          push_byte(ACT_BYTE, 8'($urandom_range(254)));
        end
      end
      push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_BYTE, CMD_SE);
    end else if (r < 93) begin
      push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_BYTE, 8'($urandom_range(255)));
    end else if (r < 97) begin
      push_byte(ACT_BYTE, 8'($urandom_range(255)));
    end else begin
      // new connection, sometimes cutting a command short
      if ($urandom_range(1)) push_byte(ACT_BYTE, CMD_IAC);
      push_byte(ACT_CONNECT, 8'($urandom_range(255)));
    end
  endfunction

  // offer one request, wait for it to be taken, then record its expected result
  task automatic send_req(input rx_item_t it, input int gap, input bit typed,
                          input result_t want);
    result_t pred;
    bit has;
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.action <= it.action;
    rx.rx_byte <= it.rx_byte;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    has = parse_byte(it.action, it.rx_byte, pred);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(pred);
  endtask

  // directed rows
  initial begin
    dir_rows.push_back(mk_row(ACT_BYTE, 8'h00, 1'b1, mk_data(8'h00)));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'hfe, 1'b1, mk_data(8'hfe)));
    // escaped iac
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b1, mk_data(8'hff)));
    // will echo, will unknown
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_WILL, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, OPT_ECHO, 1'b1, mk_reply(CMD_DO, OPT_ECHO)));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_WILL, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'hff, 1'b1, mk_reply(CMD_DONT, 8'hff)));
    // do sga, do unknown
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_DO, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, OPT_SGA, 1'b1, mk_reply(CMD_WILL, OPT_SGA)));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_DO, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'h00, 1'b1, mk_reply(CMD_WONT, 8'h00)));
    // dont is swallowed
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_DONT, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, OPT_ECHO, 1'b0, NO_RESULT));
    // subnegotiation with an escaped iac inside
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_SB, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_SE, 1'b0, NO_RESULT));
    // other command takes no option byte
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'hf1, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'h80, 1'b0, NO_RESULT));
    // new connection drops a pending iac
    dir_rows.push_back(mk_row(ACT_BYTE, CMD_IAC, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_CONNECT, 8'hff, 1'b0, NO_RESULT));
    dir_rows.push_back(mk_row(ACT_BYTE, 8'h7f, 1'b0, NO_RESULT));
  end

  // result side: check against the oldest expectation, drive ready with stalls
  initial begin
    int seg_left;
    int hold_left;
    logic level;
    int r;
    result_t got;
    result_t want;
    seg_left = 0;
    hold_left = 0;
    level = 1'b0;
    tx.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx.valid && tx.ready) begin
        got = {tx.result_kind, tx.data_byte, tx.reply_verb, tx.reply_option};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind %0d data %02h verb %02h option %02h",
                     got.result_kind, got.data_byte, got.reply_verb, got.reply_option);
        end else begin
          want = pending_results.pop_front();
          if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
              got.reply_verb !== want.reply_verb || got.reply_option !== want.reply_option) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d data %02h verb %02h option %02h,",
                       want.result_kind, want.data_byte, want.reply_verb, want.reply_option,
                       " got kind %0d data %02h verb %02h option %02h",
                       got.result_kind, got.data_byte, got.reply_verb, got.reply_option);
          end
        end
      end
      // long hold-off on request, otherwise random ready segments
      if (hold_left == 0 && long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          r = $urandom_range(99);
          if (r < 50) begin
            level = 1'b1;
            seg_left = $urandom_range(8, 1);
          end else if (r < 58) begin
            level = 1'b1;
            seg_left = $urandom_range(60, 30);
          end else if (r < 85) begin
            level = 1'b0;
            seg_left = $urandom_range(3, 1);
          end else if (r < 96) begin
            level = 1'b0;
            seg_left = $urandom_range(12, 4);
          end else begin
            level = 1'b0;
            seg_left = $urandom_range(40, 20);
          end
        end
        seg_left--;
        tx.ready <= level;
      end
    end
  end

  // timeout
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // reset, stimulus and end of run
  initial begin
    rx_item_t it;
    int waited;
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.action = ACT_BYTE;
    rx.rx_byte = 8'h00;
    parse_st = PH_DATA;
    held_verb = 8'h00;
    while (stim_q.size() < RAND_ITEMS) add_sequence();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, pick_gap(), dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < stim_q.size(); i++) begin
      // receiver stalls long while requests keep coming
      if (i == PRESS_AT) begin
        long_hold_req = 1'b1;
        for (int j = 0; j < BURST_LEN; j++) begin
          it.action = ACT_BYTE;
          it.rx_byte = 8'($urandom_range(254));
          send_req(it, 0, 1'b0, NO_RESULT);
        end
      end
      // sender waits for the pipe to drain
      if (i == DRAIN_AT) begin
        rx.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_req(stim_q[i], pick_gap(), 1'b0, NO_RESULT);
    end
    rx.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tip_pkg.sv
design/tip_if.sv
design/tip_in_reg.sv
design/tip_parser.sv
design/tip_out_reg.sv
design/telnet_iac_stream_parser.sv
design/tip_checker.sv
tb/sv/telnet_iac_stream_parser_tb.sv
